/* hdl/bht_pkg.sv */
// ----------------------------------------------------------------------------
// bht_pkg
// shared types, sizes and codes for the bucketed hash table
// ----------------------------------------------------------------------------
package bht_pkg;

    localparam int BUCKETS   = 10;
    localparam int SLOTS     = 5;
    localparam int KEY_BITS  = 16;
    localparam int DATA_BITS = 64;

    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // reciprocal for key modulo bucket count
    localparam int          MOD_SHIFT = KEY_BITS + 8;
    localparam int          MOD_MUL_W = MOD_SHIFT;
    localparam longint      MOD_MUL   = (64'd1 << MOD_SHIFT) / BUCKETS;
    localparam int          PROD_W    = KEY_BITS + MOD_MUL_W;
    localparam int          REM_W     = KEY_BITS + 9;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] req_key;
        logic [63:0] req_payload;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] hit_payload;
        logic [2:0]  slot_index;
    } t_rsp;

    typedef struct packed {
        t_req             req;
        logic [BKT_W-1:0] bucket;
    } t_cmd;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key;
        logic [DATA_BITS-1:0] data;
    } t_slot;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

/* hdl/bht_front.sv */
// ----------------------------------------------------------------------------
// bht_front
// takes request words and works out the bucket of each key
// ----------------------------------------------------------------------------
module bht_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    input  bht_pkg::t_req i_req,
    input  bht_pkg::t_qstat i_qstat,
    output logic          o_push,
    output bht_pkg::t_cmd o_cmd
);
    import bht_pkg::*;

    logic                r_s1_vld;
    t_req                r_s1_req;
    logic [PROD_W-1:0]   r_s1_prod;

    logic [KEY_BITS-1:0] key;
    logic [KEY_BITS-1:0] q_est;
    logic [REM_W-1:0]    rem_raw;
    logic [REM_W-1:0]    rem_fix;
    logic                accept;

    assign key    = r_s1_req.req_key[KEY_BITS-1:0];
    assign o_busy = r_s1_vld | i_qstat.full;
    assign accept = i_start & ~o_busy;
    assign o_push = r_s1_vld & ~i_qstat.full;

    // quotient estimate is exact or one low
    always_comb begin
        q_est   = KEY_BITS'(r_s1_prod >> MOD_SHIFT);
        rem_raw = REM_W'(key) - REM_W'(REM_W'(q_est) * REM_W'(BUCKETS));
        rem_fix = (rem_raw >= REM_W'(BUCKETS)) ? rem_raw - REM_W'(BUCKETS) : rem_raw;
        o_cmd.req    = r_s1_req;
        o_cmd.bucket = BKT_W'(rem_fix);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (o_push) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_req  <= i_req;
            r_s1_prod <= PROD_W'(i_req.req_key[KEY_BITS-1:0]) * PROD_W'(MOD_MUL_W'(MOD_MUL));
        end
    end

endmodule

/* hdl/bht_queue.sv */
// ----------------------------------------------------------------------------
// bht_queue
// short command queue between the front and the back
// ----------------------------------------------------------------------------
module bht_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bht_pkg::t_cmd   i_cmd,
    input  logic            i_pop,
    output bht_pkg::t_cmd   o_cmd,
    output bht_pkg::t_qstat o_qstat
);
    import bht_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_qstat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign do_push = i_push & ~o_qstat.full;
    assign do_pop  = i_pop & ~o_qstat.empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

/* hdl/bht_back.sv */
// ----------------------------------------------------------------------------
// bht_back
// reads one bucket row, matches all slots, fills a free slot on insert and frees a hit on delete
// ----------------------------------------------------------------------------
module bht_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bht_pkg::t_cmd   i_cmd,
    input  bht_pkg::t_qstat i_qstat,
    output logic            o_pop,
    output logic            o_done,
    output bht_pkg::t_rsp   o_rsp
);
    import bht_pkg::*;

    typedef enum logic [1:0] {
        S_FETCH = 2'b01,
        S_EXEC  = 2'b10
    } t_state;

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    t_slot [SLOTS-1:0] r_row;
    t_slot [SLOTS-1:0] r_mem [BUCKETS];
    logic [SLOTS-1:0]  r_valid [BUCKETS];
    logic              r_done;
    t_rsp              r_rsp;
    t_rsp              n_rsp;

    logic [SLOTS-1:0]  vrow;
    logic              has_free;
    logic [SLOT_W-1:0] free_idx;
    logic              has_hit;
    logic [SLOT_W-1:0] hit_idx;
    logic              exec;
    logic              do_ins;
    logic              do_del;

    assign exec  = (r_state == S_EXEC);
    assign o_pop = (r_state == S_FETCH) & ~i_qstat.empty;
    assign vrow  = r_valid[r_cmd.bucket];

    always_comb begin
        has_free = 1'b0;
        free_idx = '0;
        has_hit  = 1'b0;
        hit_idx  = '0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!vrow[s]) begin
                has_free = 1'b1;
                free_idx = SLOT_W'(s);
            end
            if (vrow[s] && r_row[s].key == r_cmd.req.req_key[KEY_BITS-1:0]) begin
                has_hit = 1'b1;
                hit_idx = SLOT_W'(s);
            end
        end
    end

    assign do_ins = exec & (r_cmd.req.req_type == OP_INSERT) & has_free;
    assign do_del = exec & (r_cmd.req.req_type == OP_DELETE) & has_hit;

    always_comb begin
        n_rsp.status      = ST_MISS;
        n_rsp.hit_payload = '0;
        n_rsp.slot_index  = '0;
        case (r_cmd.req.req_type)
            OP_INSERT: begin
                if (has_free) begin
                    n_rsp.status     = ST_DONE;
                    n_rsp.slot_index = 3'(free_idx);
                end else begin
                    n_rsp.status = ST_FULL;
                end
            end
            OP_LOOKUP: begin
                if (has_hit) begin
                    n_rsp.status      = ST_DONE;
                    n_rsp.hit_payload = 64'(r_row[hit_idx].data);
                    n_rsp.slot_index  = 3'(hit_idx);
                end
            end
            OP_DELETE: begin
                if (has_hit) begin
                    n_rsp.status     = ST_DONE;
                    n_rsp.slot_index = 3'(hit_idx);
                end
            end
            default: begin
                n_rsp.status = ST_MISS;
            end
        endcase
    end

    always_comb begin
        case (r_state)
            S_FETCH: n_state = i_qstat.empty ? S_FETCH : S_EXEC;
            S_EXEC:  n_state = S_FETCH;
            default: n_state = S_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_FETCH;
            r_done  <= 1'b0;
            for (int b = 0; b < BUCKETS; b++) begin
                r_valid[b] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_done  <= exec;
            if (do_ins) begin
                r_valid[r_cmd.bucket][free_idx] <= 1'b1;
            end else if (do_del) begin
                r_valid[r_cmd.bucket][hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
            r_row <= r_mem[i_cmd.bucket];
        end
        if (do_ins) begin
            r_mem[r_cmd.bucket][free_idx] <= t_slot'{
                key:  r_cmd.req.req_key[KEY_BITS-1:0],
                data: r_cmd.req.req_payload[DATA_BITS-1:0]
            };
        end
        if (exec) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTHESIS
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state == S_EXEC))
        else $error("result word without an executed request");

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_FETCH) && r_done)
        else $error("execute step did not complete in one cycle");

    a_insert_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> $countones(r_valid[r_cmd.bucket])
                   == $countones($past(r_valid[r_cmd.bucket])) + 1)
        else $error("insert did not claim exactly one slot");

    a_delete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_del |=> $countones(r_valid[r_cmd.bucket])
                   == $countones($past(r_valid[r_cmd.bucket])) - 1)
        else $error("delete did not release exactly one slot");
`endif

endmodule

/* hdl/bucketed_hash_table.sv */
// ----------------------------------------------------------------------------
// bucketed_hash_table
// hash table of buckets of slots, keyed by key modulo bucket count
// ----------------------------------------------------------------------------
// channel   ports                 handshake
// request   start, busy, i_req    taken when start is high and busy is low
// result    o_done, o_rsp         one cycle per word, no back-pressure
//
// in the front the bucket multiply is registered and the remainder is taken from it;
// in the back the row is read in the fetch state, then matched and written back in exec
// the back ends each request before it fetches the next, and that row access sets the rate
// synchronous active-low reset clears all slot valid bits at once
// busy rises while the front holds a word or the queue is full
// ----------------------------------------------------------------------------
module bucketed_hash_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  bht_pkg::t_req i_req,
    output logic          o_done,
    output bht_pkg::t_rsp o_rsp
);
    import bht_pkg::*;

    logic   push;
    logic   pop;
    t_cmd   front_cmd;
    t_cmd   head_cmd;
    t_qstat qstat;

    bht_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_req   (i_req),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    bht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_qstat (qstat)
    );

    bht_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

endmodule

/* bench/bucketed_hash_table_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bucketed_hash_table_tb
// self-checking bench: a directed table of insert, lookup, delete and unused
// requests, then random traffic over a small key pool so buckets fill, overflow
// and drain; each result is checked against its table row or a behavioural model
// ----------------------------------------------------------------------------
module bucketed_hash_table_tb;

    import bht_pkg::*;

    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [63:0] ALL1      = {64{1'b1}};
    localparam logic [63:0] ALT5      = 64'h5555_5555_5555_5555;
    localparam logic [63:0] ALTA      = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam int          N_DIR     = 23;
    localparam int          N_RAND    = 930;
    localparam int          MAX_SHOWN = 32;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] key;
        logic [63:0] payload;
        logic        fixed;
        logic [1:0]  status;
        logic [63:0] hit_payload;
        logic [2:0]  slot_index;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [0:N_DIR-1] = '{
        {OP_LOOKUP, 16'd0,     64'd0, 1'b1, ST_MISS, 64'd0, 3'd0},
        {OP_DELETE, 16'd65535, 64'd0, 1'b1, ST_MISS, 64'd0, 3'd0},
        {OP_UNUSED, 16'd5,     ALL1,  1'b1, ST_MISS, 64'd0, 3'd0},
        {OP_INSERT, 16'd0,     64'd0, 1'b1, ST_DONE, 64'd0, 3'd0},
        {OP_INSERT, 16'd10,    ALL1,  1'b1, ST_DONE, 64'd0, 3'd1},
        {OP_INSERT, 16'd20,    ALT5,  1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_INSERT, 16'd30,    ALTA,  1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_INSERT, 16'd0,     ALTA,  1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_INSERT, 16'd40,    ALL1,  1'b1, ST_FULL, 64'd0, 3'd0},
        {OP_LOOKUP, 16'd10,    64'd0, 1'b1, ST_DONE, ALL1,  3'd1},
        {OP_LOOKUP, 16'd0,     ALL1,  1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_DELETE, 16'd0,     64'd0, 1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_LOOKUP, 16'd0,     64'd0, 1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_INSERT, 16'd50,    ALT5,  1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_UNUSED, 16'd10,    ALL1,  1'b1, ST_MISS, 64'd0, 3'd0},
        {OP_LOOKUP, 16'd30,    64'd0, 1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_INSERT, 16'd65535, ALL1,  1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_LOOKUP, 16'd65535, 64'd0, 1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_DELETE, 16'd65535, ALL1,  1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_DELETE, 16'd65535, 64'd0, 1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_LOOKUP, 16'd65535, 64'd0, 1'b0, ST_DONE, 64'd0, 3'd0},
        {OP_LOOKUP, 16'd9,     64'd0, 1'b1, ST_MISS, 64'd0, 3'd0},
        {OP_INSERT, 16'd65534, 64'd0, 1'b0, ST_DONE, 64'd0, 3'd0}
    };

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_req  i_req;
    logic  o_done;
    t_rsp  o_rsp;

    logic              bkt_valid [BUCKETS*SLOTS];
    logic [15:0]       bkt_key   [BUCKETS*SLOTS];
    logic [63:0]       bkt_data  [BUCKETS*SLOTS];
    t_rsp              rsp_due [$];

    int n_bad;
    int n_words;
    int n_sent;
    int n_insert;
    int n_full;
    int n_found;
    int n_miss;
    int n_unused;

    bucketed_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #2ms;
        $display("timeout with %0d words still due", rsp_due.size());
        $display("bucketed_hash_table: mismatch");
        $finish;
    end

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (n_bad < MAX_SHOWN) begin
            $display("%0t: %s got %h want %h", $realtime, what, got, want);
        end
        n_bad++;
    endtask

    // one request applied to the bucket image, returning the word it yields
    function automatic t_rsp hash_table_access(input t_req r);
        t_rsp rsp;
        int   base;
        int   hit_slot;
        rsp.status      = ST_MISS;
        rsp.hit_payload = '0;
        rsp.slot_index  = '0;
        base     = (int'(r.req_key) % BUCKETS) * SLOTS;
        hit_slot = -1;
        case (r.req_type)
            OP_INSERT: begin
                for (int s = SLOTS - 1; s >= 0; s--) begin
                    if (!bkt_valid[base+s]) hit_slot = s;
                end
                if (hit_slot < 0) begin
                    rsp.status = ST_FULL;
                end else begin
                    bkt_valid[base+hit_slot] = 1'b1;
                    bkt_key[base+hit_slot]   = r.req_key;
                    bkt_data[base+hit_slot]  = r.req_payload;
                    rsp.status     = ST_DONE;
                    rsp.slot_index = 3'(hit_slot);
                end
            end
            OP_LOOKUP, OP_DELETE: begin
                for (int s = SLOTS - 1; s >= 0; s--) begin
                    if (bkt_valid[base+s] && bkt_key[base+s] == r.req_key) hit_slot = s;
                end
                if (hit_slot >= 0) begin
                    rsp.status     = ST_DONE;
                    rsp.slot_index = 3'(hit_slot);
                    if (r.req_type == OP_LOOKUP) begin
                        rsp.hit_payload = bkt_data[base+hit_slot];
                    end else begin
                        bkt_valid[base+hit_slot] = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic send_word(input t_req r, input int gap, input bit fixed,
                             input t_rsp fixed_rsp);
        t_rsp want;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        want = hash_table_access(r);
        n_sent++;
        if (r.req_type == OP_UNUSED) n_unused++;
        else if (want.status == ST_FULL) n_full++;
        else if (want.status == ST_MISS) n_miss++;
        else if (r.req_type == OP_INSERT) n_insert++;
        else n_found++;
        rsp_due.push_back(fixed ? fixed_rsp : want);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (rsp_due.size() > 0);
    endtask

    always @(posedge i_clk) begin : check_rsp
        t_rsp want;
        if (i_rst_n && o_done) begin
            n_words++;
            if (rsp_due.size() == 0) begin
                note_mismatch("result word with none due, hit_payload",
                              o_rsp.hit_payload, 64'd0);
            end else begin
                want = rsp_due.pop_front();
                if (o_rsp.status !== want.status)
                    note_mismatch("status", 64'(o_rsp.status), 64'(want.status));
                if (o_rsp.hit_payload !== want.hit_payload)
                    note_mismatch("hit_payload", o_rsp.hit_payload, want.hit_payload);
                if (o_rsp.slot_index !== want.slot_index)
                    note_mismatch("slot_index", 64'(o_rsp.slot_index),
                                  64'(want.slot_index));
            end
        end
    end

    initial begin : stimulus
        t_req     r;
        t_rsp     fixed_rsp;
        t_dir_row row;
        bit       no_idle;
        int       pick;
        int       phase;
        int       wait_cycles;

        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        n_bad = 0; n_words = 0; n_sent = 0; n_insert = 0;
        n_full = 0; n_found = 0; n_miss = 0; n_unused = 0;
        for (int i = 0; i < BUCKETS*SLOTS; i++) begin
            bkt_valid[i] = 1'b0;
            bkt_key[i]   = '0;
            bkt_data[i]  = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIR; i++) begin
            row = DIR_ROWS[i];
            r.req_type    = row.op;
            r.req_key     = row.key;
            r.req_payload = row.payload;
            fixed_rsp.status      = row.status;
            fixed_rsp.hit_payload = row.hit_payload;
            fixed_rsp.slot_index  = row.slot_index;
            send_word(r, (i < 8) ? 0 : $urandom_range(0, 14), row.fixed, fixed_rsp);
        end
        wait_drained();

        no_idle = 1'b0;
        for (int i = 0; i < N_RAND; i++) begin
            if (i % 50 == 0) no_idle = ($urandom_range(0, 2) == 0);
            if (i == 400) wait_drained();
            // fill, mixed and drain phases so buckets overflow and empty again
            phase = (i / 120) % 3;
            pick  = $urandom_range(0, 99);
            if (pick < 5) r.req_type = OP_UNUSED;
            else if (pick < ((phase == 0) ? 65 : (phase == 1) ? 40 : 20)) r.req_type = OP_INSERT;
            else if (pick < ((phase == 2) ? 55 : 75)) r.req_type = OP_LOOKUP;
            else r.req_type = OP_DELETE;
            pick = $urandom_range(0, 99);
            if (pick < 70) r.req_key = 16'($urandom_range(0, 69));
            else if (pick < 85) r.req_key = 16'(65535 - $urandom_range(0, 69));
            else r.req_key = 16'($urandom);
            pick = $urandom_range(0, 19);
            if (pick == 0) r.req_payload = 64'd0;
            else if (pick == 1) r.req_payload = ALL1;
            else r.req_payload = {32'($urandom), 32'($urandom)};
            send_word(r, no_idle ? 0 : $urandom_range(0, 14), 1'b0, '0);
        end
        start <= 1'b0;

        wait_cycles = 0;
        while (rsp_due.size() > 0 && wait_cycles < 1000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        if (rsp_due.size() > 0) begin
            note_mismatch("result words never arrived, count",
                          64'(rsp_due.size()), 64'd0);
        end
        repeat (16) @(posedge i_clk);

        $display("sent %0d requests: %0d stored, %0d bucket full, %0d found, %0d missed, %0d unused",
                 n_sent, n_insert, n_full, n_found, n_miss, n_unused);
        $display("checked %0d result words, %0d mismatches", n_words, n_bad);
        if (n_bad == 0) begin
            $display("bucketed_hash_table: match");
        end else begin
            $display("bucketed_hash_table: mismatch");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/bht_pkg.sv
hdl/bht_front.sv
hdl/bht_queue.sv
hdl/bht_back.sv
hdl/bucketed_hash_table.sv
bench/bucketed_hash_table_tb.sv
